FILE: rtl/core/cfpc_pkg.sv
// cfpc_pkg: shared types and constants for the command frame ptt controller
// no dependencies; used by the interfaces, the parser and the top level
package cfpc_pkg;

    localparam int unsigned BUFFER_BYTES = 1024;
    localparam int unsigned LEFT_W       = $clog2(BUFFER_BYTES);
    localparam int unsigned TIMEOUT_W    = 26;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned OP_W         = 2;
    localparam int unsigned KIND_W       = 3;

    localparam logic [BYTE_W-1:0] CODE_SERIAL = 8'd1;
    localparam logic [BYTE_W-1:0] CODE_PTT    = 8'd2;
    localparam logic [BYTE_W-1:0] CODE_RELAY  = 8'd3;
    localparam logic [BYTE_W-1:0] CODE_AUDIO  = 8'd4;
    localparam logic [BYTE_W-1:0] CODE_CONFIG = 8'd5;

    localparam logic [BYTE_W-1:0] KEY_TX_GAIN = 8'h01;
    localparam logic [BYTE_W-1:0] KEY_UPDATE  = 8'hFF;

    localparam logic [BYTE_W-1:0]    GAIN_RESET    = 8'd128;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 26'd180000;
    localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [15:0]          LEN_LIMIT     = 16'(BUFFER_BYTES - 3);

    typedef enum logic [OP_W-1:0] {
        OP_BYTE       = 2'd0,
        OP_TICK       = 2'd1,
        OP_LINK_OPEN  = 2'd2,
        OP_LINK_CLOSE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_RADIO   = 3'd1,
        KIND_DAC     = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_UPDATE  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_CODE    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_ARG     = 3'd4,
        PH_KEY     = 3'd5,
        PH_VALUE   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] out_byte;
        logic              ptt_on;
        logic              serial_mode;
        logic              audio_on;
        logic              frame_dropped;
    } out_item_t;

endpackage

FILE: rtl/core/cfpc_ifs.sv
// cfpc channel interfaces: input items, result items and the timeout write channel
// depends on cfpc_pkg for field widths
interface cfpc_req_if;
    logic                              valid;
    logic                              ready;
    logic [cfpc_pkg::OP_W-1:0]         op;
    logic [cfpc_pkg::BYTE_W-1:0]       data_byte;

    modport source (output valid, op, data_byte, input ready);
    modport sink   (input valid, op, data_byte, output ready);
endinterface

interface cfpc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [cfpc_pkg::KIND_W-1:0]       kind;
    logic [cfpc_pkg::BYTE_W-1:0]       out_byte;
    logic                              ptt_on;
    logic                              serial_mode;
    logic                              audio_on;
    logic                              frame_dropped;

    modport source (output valid, kind, out_byte, ptt_on, serial_mode, audio_on,
                    frame_dropped, input ready);
    modport sink   (input valid, kind, out_byte, ptt_on, serial_mode, audio_on,
                    frame_dropped, output ready);
endinterface

interface cfpc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cfpc_pkg::TIMEOUT_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/cfpc_parser.sv
// cfpc_parser: frame parser, ptt timer, relay and gain state; one item per step
// depends on cfpc_pkg; result is combinational and registered by the top level
module cfpc_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  cfpc_pkg::in_item_t               item,
    input  logic [cfpc_pkg::TIMEOUT_W-1:0]   timeout,
    output cfpc_pkg::out_item_t              result
);
    import cfpc_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [BYTE_W-1:0]     frame_code_reg, frame_code_next;
    logic [BYTE_W-1:0]     length_high_reg, length_high_next;
    logic [LEFT_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0]     pending_key_reg, pending_key_next;
    logic                  ptt_active_reg, ptt_active_next;
    logic [TIMEOUT_W-1:0]  ptt_elapsed_reg, ptt_elapsed_next;
    logic                  relay_serial_reg, relay_serial_next;
    logic                  audio_enabled_reg, audio_enabled_next;
    logic [BYTE_W-1:0]     tx_gain_reg, tx_gain_next;
    logic                  link_up_reg, link_up_next;
    logic                  halted_reg, halted_next;

    logic                  live;
    logic                  byte_step;
    logic [BYTE_W-1:0]     b;
    logic                  code_len, code_arg, code_cfg;
    logic [15:0]           len;
    logic                  len_big, len_zero;
    logic [LEFT_W-1:0]     left_dec;
    logic [15:0]           product;
    logic [BYTE_W:0]       scaled;
    logic [BYTE_W-1:0]     sample;
    logic [TIMEOUT_W-1:0]  elapsed_inc;

    assign live      = step && !halted_reg;
    assign byte_step = live && (op_t'(item.op) == OP_BYTE);
    assign b         = item.data_byte;
    assign code_len  = (b == CODE_SERIAL) || (b == CODE_AUDIO);
    assign code_arg  = (b == CODE_PTT) || (b == CODE_RELAY);
    assign code_cfg  = (b == CODE_CONFIG);
    assign len       = {length_high_reg, b};
    assign len_big   = len > LEN_LIMIT;
    assign len_zero  = (len == 16'd0);
    assign left_dec  = bytes_left_reg - LEFT_W'(1);
    assign product   = 16'(b) * 16'(tx_gain_reg);
    assign scaled    = product[BYTE_W+7:7];
    assign sample    = scaled[BYTE_W] ? '1 : scaled[BYTE_W-1:0];
    assign elapsed_inc = (ptt_elapsed_reg == ELAPSED_MAX) ? ptt_elapsed_reg
                                                          : ptt_elapsed_reg + TIMEOUT_W'(1);

    // parser phase
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_step)
        begin
            case (phase_reg)
                PH_CODE:
                begin
                    if (code_len)
                        phase_next = PH_LEN_HI;
                    else if (code_arg)
                        phase_next = PH_ARG;
                    else if (code_cfg)
                        phase_next = PH_KEY;
                    else
                        phase_next = PH_CODE;
                end
                PH_LEN_HI:  phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = (len_big || len_zero) ? PH_CODE : PH_PAYLOAD;
                PH_PAYLOAD: phase_next = (left_dec == '0) ? PH_CODE : PH_PAYLOAD;
                PH_KEY:     phase_next = PH_VALUE;
                PH_ARG,
                PH_VALUE:   phase_next = PH_CODE;
                default:    phase_next = PH_CODE;
            endcase
        end
    end

    // datapath state and result
    always_comb
    begin
        frame_code_next    = frame_code_reg;
        length_high_next   = length_high_reg;
        bytes_left_next    = bytes_left_reg;
        pending_key_next   = pending_key_reg;
        ptt_active_next    = ptt_active_reg;
        ptt_elapsed_next   = ptt_elapsed_reg;
        relay_serial_next  = relay_serial_reg;
        audio_enabled_next = audio_enabled_reg;
        tx_gain_next       = tx_gain_reg;
        link_up_next       = link_up_reg;
        halted_next        = halted_reg;
        result.kind          = KIND_NONE;
        result.out_byte      = '0;
        result.frame_dropped = 1'b0;

        if (live)
        begin
            case (op_t'(item.op))
                OP_BYTE:
                begin
                    case (phase_reg)
                        PH_CODE:
                        begin
                            frame_code_next = b;
                            if (!code_len && !code_arg && !code_cfg)
                                result.frame_dropped = 1'b1;
                        end
                        PH_LEN_HI: length_high_next = b;
                        PH_LEN_LO:
                        begin
                            if (len_big)
                                result.frame_dropped = 1'b1;
                            else if (!len_zero)
                                bytes_left_next = len[LEFT_W-1:0];
                        end
                        PH_PAYLOAD:
                        begin
                            bytes_left_next = left_dec;
                            if (frame_code_reg == CODE_SERIAL)
                            begin
                                result.kind     = KIND_RADIO;
                                result.out_byte = b;
                            end
                            else
                            begin
                                result.kind     = KIND_DAC;
                                result.out_byte = sample;
                            end
                        end
                        PH_ARG:
                        begin
                            if (frame_code_reg == CODE_PTT)
                            begin
                                if (b != '0 && !ptt_active_reg)
                                begin
                                    ptt_active_next  = 1'b1;
                                    ptt_elapsed_next = '0;
                                end
                                else if (b == '0)
                                    ptt_active_next = 1'b0;
                            end
                            else
                            begin
                                relay_serial_next  = (b != '0);
                                audio_enabled_next = (b == '0);
                            end
                        end
                        PH_KEY: pending_key_next = b;
                        PH_VALUE:
                        begin
                            if (pending_key_reg == KEY_TX_GAIN)
                                tx_gain_next = b;
                            else if (pending_key_reg == KEY_UPDATE)
                            begin
                                ptt_active_next   = 1'b0;
                                relay_serial_next = 1'b0;
                                link_up_next      = 1'b0;
                                halted_next       = 1'b1;
                                result.kind       = KIND_UPDATE;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_TICK:
                begin
                    if (ptt_active_reg)
                    begin
                        ptt_elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout)
                        begin
                            ptt_active_next = 1'b0;
                            if (link_up_reg)
                                result.kind = KIND_TIMEOUT;
                        end
                    end
                end
                OP_LINK_OPEN: link_up_next = 1'b1;
                OP_LINK_CLOSE:
                begin
                    link_up_next       = 1'b0;
                    ptt_active_next    = 1'b0;
                    relay_serial_next  = 1'b0;
                    audio_enabled_next = 1'b0;
                end
                default: ;
            endcase
        end

        result.ptt_on      = ptt_active_next;
        result.serial_mode = relay_serial_next;
        result.audio_on    = audio_enabled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_CODE;
            frame_code_reg    <= '0;
            length_high_reg   <= '0;
            bytes_left_reg    <= '0;
            pending_key_reg   <= '0;
            ptt_active_reg    <= 1'b0;
            ptt_elapsed_reg   <= '0;
            relay_serial_reg  <= 1'b0;
            audio_enabled_reg <= 1'b0;
            tx_gain_reg       <= GAIN_RESET;
            link_up_reg       <= 1'b0;
            halted_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            frame_code_reg    <= frame_code_next;
            length_high_reg   <= length_high_next;
            bytes_left_reg    <= bytes_left_next;
            pending_key_reg   <= pending_key_next;
            ptt_active_reg    <= ptt_active_next;
            ptt_elapsed_reg   <= ptt_elapsed_next;
            relay_serial_reg  <= relay_serial_next;
            audio_enabled_reg <= audio_enabled_next;
            tx_gain_reg       <= tx_gain_next;
            link_up_reg       <= link_up_next;
            halted_reg        <= halted_next;
        end
    end

`ifndef ASSERT_OFF
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (step && halted_reg) |-> (result.kind == KIND_NONE && !result.frame_dropped))
        else $error("halted block produced a result");

    a_timeout_release: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.kind == KIND_TIMEOUT) |-> (!result.ptt_on && link_up_reg))
        else $error("timeout notify without ptt release or link");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (bytes_left_reg != '0))
        else $error("payload phase with no bytes left");
`endif

endmodule

FILE: rtl/core/command_frame_ptt_controller.sv
// command_frame_ptt_controller: the result is registered after item accept
// (input register, then result register) and waits longer while rsp stalls;
// one item per cycle while rsp.ready keeps up, the parser and 8x8 gain multiply
// sit in one stage between the two registers
// reset: async active low; parser expects a command code, ptt, relay, audio and
// link cleared, tx gain 128, ptt timeout 180000 ms; config taken in any cycle
module command_frame_ptt_controller (
    input  logic        clk,
    input  logic        rst_n,
    cfpc_req_if.sink    req,
    cfpc_rsp_if.source  rsp,
    cfpc_cfg_if.sink    cfg
);
    import cfpc_pkg::*;

    logic                  s1_valid_reg;
    in_item_t              s1_item_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic                  adv;
    out_item_t             result;

    assign adv       = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || adv;
    assign cfg.ready = 1'b1;

    cfpc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .item    (s1_item_reg),
        .timeout (timeout_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            if (req.valid && req.ready)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
                timeout_reg <= cfg.data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg.op        <= req.op;
            s1_item_reg.data_byte <= req.data_byte;
        end
        if (adv)
            out_item_reg <= result;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_item_reg.kind;
    assign rsp.out_byte      = out_item_reg.out_byte;
    assign rsp.ptt_on        = out_item_reg.ptt_on;
    assign rsp.serial_mode   = out_item_reg.serial_mode;
    assign rsp.audio_on      = out_item_reg.audio_on;
    assign rsp.frame_dropped = out_item_reg.frame_dropped;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("input accepted while both stages are full");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(s1_valid_reg))
        else $error("result appeared without a held item");

    a_no_drop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> out_valid_reg)
        else $error("stalled result lost");
`endif

endmodule

FILE: sim/command_frame_ptt_controller_tb.sv
// testbench for command_frame_ptt_controller: drives phone bytes, ticks and link events,
// predicts each result item from an internal copy of the frame parser and ptt timer
// depends on cfpc_pkg and the cfpc channel interfaces
module command_frame_ptt_controller_tb;

    import cfpc_pkg::*;

    localparam int                   WATCHDOG_LIMIT  = 4000;
    localparam int                   REPORT_LIMIT    = 10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_LONGEST = 26'd65535000;
    localparam logic [BYTE_W-1:0]    SAMPLE_MAX      = 8'hFF;
    localparam logic [15:0]          LONG_FRAME_LEN  = 16'd300;

    logic clk = 1'b0;
    logic rst_n;

    cfpc_req_if req_ch ();
    cfpc_rsp_if rsp_ch ();
    cfpc_cfg_if cfg_ch ();

    command_frame_ptt_controller i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted controller state
    phase_t               pr_phase    = PH_CODE;
    logic [BYTE_W-1:0]    pr_code     = '0;
    logic [BYTE_W-1:0]    pr_len_hi   = '0;
    logic [LEFT_W-1:0]    pr_left     = '0;
    logic [BYTE_W-1:0]    pr_key      = '0;
    logic                 pr_ptt      = 1'b0;
    logic [TIMEOUT_W-1:0] pr_elapsed  = '0;
    logic                 pr_relay    = 1'b0;
    logic                 pr_audio    = 1'b0;
    logic [BYTE_W-1:0]    pr_gain     = GAIN_RESET;
    logic                 pr_link     = 1'b0;
    logic                 pr_halted   = 1'b0;
    logic [TIMEOUT_W-1:0] pr_timeout  = TIMEOUT_RESET;

    out_item_t due_results[$];
    int        mismatch_count = 0;
    int        items_sent     = 0;
    int        src_idle_pct   = 0;
    int        sink_idle_pct  = 0;
    int        stall_request  = 0;
    int        stall_left     = 0;
    int        quiet_cycles   = 0;
    logic      update_allowed = 1'b0;

    function automatic out_item_t step_controller(input op_t op, input logic [BYTE_W-1:0] b);
        out_item_t   r;
        logic [15:0] frame_len;
        logic [15:0] product;
        r = '0;
        if (!pr_halted)
        begin
            case (op)
                OP_BYTE:
                begin
                    case (pr_phase)
                        PH_CODE:
                        begin
                            pr_code = b;
                            if (b == CODE_SERIAL || b == CODE_AUDIO)
                                pr_phase = PH_LEN_HI;
                            else if (b == CODE_PTT || b == CODE_RELAY)
                                pr_phase = PH_ARG;
                            else if (b == CODE_CONFIG)
                                pr_phase = PH_KEY;
                            else
                                r.frame_dropped = 1'b1;
                        end
                        PH_LEN_HI:
                        begin
                            pr_len_hi = b;
                            pr_phase = PH_LEN_LO;
                        end
                        PH_LEN_LO:
                        begin
                            frame_len = {pr_len_hi, b};
                            if (frame_len > LEN_LIMIT)
                            begin
                                r.frame_dropped = 1'b1;
                                pr_phase = PH_CODE;
                            end
                            else if (frame_len == 16'd0)
                                pr_phase = PH_CODE;
                            else
                            begin
                                pr_left = frame_len[LEFT_W-1:0];
                                pr_phase = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            if (pr_code == CODE_SERIAL)
                            begin
                                r.kind = KIND_RADIO;
                                r.out_byte = b;
                            end
                            else
                            begin
                                product = 16'(b) * 16'(pr_gain);
                                r.kind = KIND_DAC;
                                r.out_byte = (product[15:7] > 9'd255) ? SAMPLE_MAX : product[14:7];
                            end
                            pr_left = pr_left - 1'b1;
                            if (pr_left == '0)
                                pr_phase = PH_CODE;
                        end
                        PH_ARG:
                        begin
                            if (pr_code == CODE_PTT)
                            begin
                                if (b != '0 && !pr_ptt)
                                begin
                                    pr_ptt = 1'b1;
                                    pr_elapsed = '0;
                                end
                                else if (b == '0 && pr_ptt)
                                    pr_ptt = 1'b0;
                            end
                            else
                            begin
                                pr_relay = (b != '0);
                                pr_audio = (b == '0);
                            end
                            pr_phase = PH_CODE;
                        end
                        PH_KEY:
                        begin
                            pr_key = b;
                            pr_phase = PH_VALUE;
                        end
                        PH_VALUE:
                        begin
                            if (pr_key == KEY_TX_GAIN)
                                pr_gain = b;
                            else if (pr_key == KEY_UPDATE)
                            begin
                                pr_ptt = 1'b0;
                                pr_relay = 1'b0;
                                pr_link = 1'b0;
                                pr_halted = 1'b1;
                                r.kind = KIND_UPDATE;
                            end
                            pr_phase = PH_CODE;
                        end
                        default:
                            pr_phase = PH_CODE;
                    endcase
                end
                OP_TICK:
                begin
                    if (pr_ptt)
                    begin
                        if (pr_elapsed != ELAPSED_MAX)
                            pr_elapsed = pr_elapsed + 1'b1;
                        if (pr_elapsed >= pr_timeout)
                        begin
                            pr_ptt = 1'b0;
                            if (pr_link)
                                r.kind = KIND_TIMEOUT;
                        end
                    end
                end
                OP_LINK_OPEN:
                    pr_link = 1'b1;
                default:
                begin
                    pr_link = 1'b0;
                    pr_ptt = 1'b0;
                    pr_relay = 1'b0;
                    pr_audio = 1'b0;
                end
            endcase
        end
        r.ptt_on = pr_ptt;
        r.serial_mode = pr_relay;
        r.audio_on = pr_audio;
        return r;
    endfunction

    task automatic send_item(input op_t op, input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] data;
        data = b;
        // keep the update key out until the last test, it halts the block
        if (op == OP_BYTE && pr_phase == PH_KEY && data == KEY_UPDATE && !update_allowed)
            data = ~KEY_UPDATE;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.data_byte <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        due_results.push_back(step_controller(op, data));
        items_sent++;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        pr_timeout = value;
    endtask

    task automatic send_random_frame();
        int          pick;
        logic [15:0] frame_len;
        if ($urandom_range(3) != 0)
            while (pr_phase != PH_CODE)
                send_item(OP_BYTE, 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            if ($urandom_range(6) == 0)
                frame_len = 16'($urandom_range(0, 65535));
            else
                frame_len = 16'($urandom_range(0, 12));
            send_item(OP_BYTE, (pick < 20) ? CODE_SERIAL : CODE_AUDIO);
            send_item(OP_BYTE, frame_len[15:8]);
            send_item(OP_BYTE, frame_len[7:0]);
            if (frame_len <= LEN_LIMIT)
                repeat (frame_len)
                begin
                    if ($urandom_range(7) == 0)
                        send_item(OP_TICK, 8'($urandom));
                    send_item(OP_BYTE, 8'($urandom));
                end
        end
        else if (pick < 60)
        begin
            send_item(OP_BYTE, (pick < 52) ? CODE_PTT : CODE_RELAY);
            send_item(OP_BYTE, $urandom_range(1) ? 8'($urandom) : 8'h00);
        end
        else if (pick < 70)
        begin
            send_item(OP_BYTE, CODE_CONFIG);
            send_item(OP_BYTE, $urandom_range(1) ? KEY_TX_GAIN : 8'($urandom));
            send_item(OP_BYTE, 8'($urandom));
        end
        else if (pick < 85)
            repeat ($urandom_range(1, 6)) send_item(OP_TICK, 8'($urandom));
        else if (pick < 90)
            send_item(OP_LINK_OPEN, 8'($urandom));
        else if (pick < 93)
            send_item(OP_LINK_CLOSE, 8'($urandom));
        else
            repeat ($urandom_range(1, 3)) send_item(op_t'($urandom_range(3)), 8'($urandom));
    endtask

    task automatic test_frame_errors();
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_BYTE, CODE_SERIAL);
        send_item(OP_BYTE, 8'h03);
        send_item(OP_BYTE, 8'hFE);
        send_item(OP_BYTE, CODE_AUDIO);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, CODE_CONFIG);
        send_item(OP_BYTE, KEY_TX_GAIN);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, CODE_AUDIO);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h03);
        send_item(OP_BYTE, 8'h02);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h00);
    endtask

    task automatic test_ptt_and_link();
        send_item(OP_LINK_OPEN, 8'h00);
        send_item(OP_BYTE, CODE_PTT);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, CODE_PTT);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_BYTE, CODE_RELAY);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_LINK_CLOSE, 8'h00);
        send_item(OP_BYTE, CODE_PTT);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_TICK, 8'h00);
    endtask

    task automatic test_long_audio_frame();
        send_item(OP_BYTE, CODE_CONFIG);
        send_item(OP_BYTE, KEY_TX_GAIN);
        send_item(OP_BYTE, 8'($urandom));
        send_item(OP_BYTE, CODE_AUDIO);
        send_item(OP_BYTE, LONG_FRAME_LEN[15:8]);
        send_item(OP_BYTE, LONG_FRAME_LEN[7:0]);
        repeat (LONG_FRAME_LEN) send_item(OP_BYTE, 8'($urandom));
    endtask

    task automatic test_random_traffic(input int count);
        int last_item;
        last_item = items_sent + count;
        while (items_sent < last_item)
            send_random_frame();
    endtask

    task automatic test_backpressure();
        stall_request = 80;
        test_random_traffic(40);
    endtask

    task automatic test_update_request();
        while (pr_phase != PH_CODE)
            send_item(OP_BYTE, 8'($urandom));
        send_item(OP_LINK_OPEN, 8'h00);
        send_item(OP_BYTE, CODE_PTT);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, CODE_RELAY);
        send_item(OP_BYTE, 8'h00);
        update_allowed = 1'b1;
        send_item(OP_BYTE, CODE_CONFIG);
        send_item(OP_BYTE, KEY_UPDATE);
        send_item(OP_BYTE, 8'($urandom));
        send_item(OP_LINK_OPEN, 8'h00);
        send_item(OP_BYTE, CODE_PTT);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_TICK, 8'h00);
        send_item(OP_LINK_CLOSE, 8'h00);
    endtask

    // result sink with random and long stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (stall_request != 0)
            begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t got;
        out_item_t exp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.kind          = kind_t'(rsp_ch.kind);
            got.out_byte      = rsp_ch.out_byte;
            got.ptt_on        = rsp_ch.ptt_on;
            got.serial_mode   = rsp_ch.serial_mode;
            got.audio_on      = rsp_ch.audio_on;
            got.frame_dropped = rsp_ch.frame_dropped;
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result item: kind %0d byte %02h", got.kind, got.out_byte);
            end
            else
            begin
                exp = due_results.pop_front();
                if (got.kind !== exp.kind || got.out_byte !== exp.out_byte
                    || got.ptt_on !== exp.ptt_on || got.serial_mode !== exp.serial_mode
                    || got.audio_on !== exp.audio_on || got.frame_dropped !== exp.frame_dropped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch exp/got: kind %0d/%0d byte %02h/%02h",
                                 exp.kind, got.kind, exp.out_byte, got.out_byte);
                        $display("  ptt %b/%b serial %b/%b audio %b/%b drop %b/%b",
                                 exp.ptt_on, got.ptt_on, exp.serial_mode, got.serial_mode,
                                 exp.audio_on, got.audio_on, exp.frame_dropped,
                                 got.frame_dropped);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("command_frame_ptt_controller_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_BYTE;
        req_ch.data_byte = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 27;
        sink_idle_pct = 72;
        write_timeout('0);
        test_frame_errors();
        test_ptt_and_link();
        write_timeout(TIMEOUT_LONGEST);
        test_long_audio_frame();
        write_timeout(TIMEOUT_W'($urandom_range(1, 24)));
        test_random_traffic(110);

        src_idle_pct  = 72;
        sink_idle_pct = 27;
        write_timeout(TIMEOUT_W'($urandom_range(1, 8)));
        test_random_traffic(110);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_timeout(TIMEOUT_W'($urandom_range(20, 60)));
        test_backpressure();
        test_random_traffic(90);
        test_update_request();

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("command_frame_ptt_controller_tb: PASS");
        else
            $display("command_frame_ptt_controller_tb: FAIL");
        $finish;
    end

endmodule
